// ===== rtl/rfook_pkg.sv =====
// ----------------------------------------------------------------------------
// rfook_pkg
// Shared widths, register indexes and symbol codes of the screen code encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rfook_pkg;

  localparam int ID_BITS    = 26;
  localparam int UNIT_BITS  = 4;
  localparam int WORD_BITS  = ID_BITS + 2 + UNIT_BITS;
  localparam int PULSE_BITS = 18;
  localparam int BASE_BITS  = 12;
  localparam int LONG_BITS  = 4;
  localparam int FOOT_BITS  = 6;
  localparam int CFG_BITS   = 12;
  localparam int IDX_BITS   = 2;
  localparam int SYM_BITS   = 6;
  localparam int CNT_BITS   = 3;

  // symbols of one command: start, one per code bit, footer
  localparam logic [SYM_BITS-1:0] LAST_SYM = SYM_BITS'(WORD_BITS + 1);

  localparam logic [FOOT_BITS-1:0] START_MULT = FOOT_BITS'(9);

  localparam logic [CNT_BITS-1:0] CNT_NONE = CNT_BITS'(0);
  localparam logic [CNT_BITS-1:0] CNT_PAIR = CNT_BITS'(2);
  localparam logic [CNT_BITS-1:0] CNT_QUAD = CNT_BITS'(4);

  localparam logic [BASE_BITS-1:0] BASE_RESET   = BASE_BITS'(303);
  localparam logic [LONG_BITS-1:0] LONG_RESET   = LONG_BITS'(5);
  localparam logic [FOOT_BITS-1:0] FOOTER_RESET = FOOT_BITS'(34);

  typedef enum logic [IDX_BITS-1:0] {
    REG_BASE_PULSE    = 2'd0,
    REG_LONG_FACTOR   = 2'd1,
    REG_FOOTER_FACTOR = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    SYM_START  = 2'd0,
    SYM_ZERO   = 2'd1,
    SYM_ONE    = 2'd2,
    SYM_FOOTER = 2'd3
  } sym_kind_t;

endpackage

`default_nettype wire

// ===== rtl/rfook_cmd_if.sv =====
// ----------------------------------------------------------------------------
// rfook_cmd_if
// Command channel: valid/ready handshake with one screen command as payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfook_cmd_if;
  import rfook_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ID_BITS-1:0]   device_id;
  logic                 all_units;
  logic                 move_up;
  logic [UNIT_BITS-1:0] unit_code;

  modport source (output valid, device_id, all_units, move_up, unit_code, input ready);
  modport sink   (input valid, device_id, all_units, move_up, unit_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/rfook_sym_if.sv =====
// ----------------------------------------------------------------------------
// rfook_sym_if
// Symbol channel: valid/ready handshake with one pulse symbol as payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfook_sym_if;
  import rfook_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            symbol_kind;
  logic [CNT_BITS-1:0]   pulse_count;
  logic [PULSE_BITS-1:0] pulse_first;
  logic [PULSE_BITS-1:0] pulse_second;
  logic [PULSE_BITS-1:0] pulse_third;
  logic [PULSE_BITS-1:0] pulse_fourth;
  logic                  last_symbol;
  logic                  bad_id;

  modport source (output valid, symbol_kind, pulse_count, pulse_first, pulse_second,
                  pulse_third, pulse_fourth, last_symbol, bad_id, input ready);
  modport sink   (input valid, symbol_kind, pulse_count, pulse_first, pulse_second,
                  pulse_third, pulse_fourth, last_symbol, bad_id, output ready);
endinterface

`default_nettype wire

// ===== rtl/rf_ook_screen_code_pulse_encoder.sv =====
// ----------------------------------------------------------------------------
// rf_ook_screen_code_pulse_encoder
// Packs a screen command into a 32-bit code word and emits its pulse symbols.
// ----------------------------------------------------------------------------
// A command with a nonzero device id produces 34 symbols, one per clock
// cycle while the output is taken: a start pair, 32 four-pulse bit symbols
// (id MSB first, all flag, state, unit MSB first) and a footer pair. A zero
// id produces a single symbol flagged bad_id and last_symbol. The symbol
// sequencer issues one symbol per cycle while the output advances; the next
// command is taken in the cycle its last symbol issues. Each symbol then
// passes three register stages (decode, multiply, assemble) after the
// sequencer. A stall on the output holds the whole pipeline. The user must
// write configuration only while no command is in flight; the block itself
// does not enforce this.
`default_nettype none

module rf_ook_screen_code_pulse_encoder (
  input  wire logic                     clk,
  input  wire logic                     rst,
  rfook_cmd_if.sink                     cmd,
  rfook_sym_if.source                   sym,
  input  wire logic                     cfg_we,
  input  wire logic [rfook_pkg::IDX_BITS-1:0] cfg_index,
  input  wire logic [rfook_pkg::CFG_BITS-1:0] cfg_data
);
  import rfook_pkg::*;

  // configuration registers
  logic [BASE_BITS-1:0] base_pulse;
  logic [LONG_BITS-1:0] long_factor;
  logic [FOOT_BITS-1:0] footer_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_pulse    <= BASE_RESET;
      long_factor   <= LONG_RESET;
      footer_factor <= FOOTER_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BASE_PULSE:    base_pulse    <= cfg_data[BASE_BITS-1:0];
        REG_LONG_FACTOR:   long_factor   <= cfg_data[LONG_BITS-1:0];
        REG_FOOTER_FACTOR: footer_factor <= cfg_data[FOOT_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !sym.valid || sym.ready;

  // symbol sequencer
  logic                 busy;
  logic                 seq_bad;
  logic [WORD_BITS-1:0] word;
  logic [SYM_BITS-1:0]  idx;
  logic                 issue;
  logic                 last_issue;
  logic                 cmd_take;

  assign issue      = busy && adv;
  assign last_issue = seq_bad || (idx == LAST_SYM);
  assign cmd.ready  = !busy || (adv && last_issue);
  assign cmd_take   = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (cmd_take) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (issue) begin
      if (last_issue) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + SYM_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      seq_bad <= (cmd.device_id == '0);
      word    <= {cmd.device_id, cmd.all_units, cmd.move_up, cmd.unit_code};
    end else if (issue && idx != '0) begin
      word <= word << 1;
    end
  end

  // stage 1: decode the symbol and pick the multiplier
  logic                 s1_valid;
  sym_kind_t            s1_kind;
  logic                 s1_last;
  logic                 s1_bad;
  logic [BASE_BITS-1:0] s1_base;
  logic [FOOT_BITS-1:0] s1_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_bad  <= seq_bad;
      s1_base <= base_pulse;
      s1_last <= last_issue;
      priority if (seq_bad || idx == '0) begin
        s1_kind   <= SYM_START;
        s1_factor <= START_MULT;
      end else if (idx == LAST_SYM) begin
        s1_kind   <= SYM_FOOTER;
        s1_factor <= footer_factor;
      end else begin
        s1_kind   <= word[WORD_BITS-1] ? SYM_ONE : SYM_ZERO;
        s1_factor <= FOOT_BITS'(long_factor);
      end
    end
  end

  // stage 2: scaled pulse
  logic                  s2_valid;
  sym_kind_t             s2_kind;
  logic                  s2_last;
  logic                  s2_bad;
  logic [BASE_BITS-1:0]  s2_base;
  logic [PULSE_BITS-1:0] s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind <= s1_kind;
      s2_last <= s1_last;
      s2_bad  <= s1_bad;
      s2_base <= s1_base;
      s2_prod <= PULSE_BITS'(s1_base) * PULSE_BITS'(s1_factor);
    end
  end

  // stage 3: output register
  logic [PULSE_BITS-1:0] b18;
  assign b18 = PULSE_BITS'(s2_base);

  always_ff @(posedge clk) begin
    if (rst) begin
      sym.valid <= 1'b0;
    end else if (adv) begin
      sym.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sym.symbol_kind <= s2_kind;
      sym.last_symbol <= s2_last;
      sym.bad_id      <= s2_bad;
      if (s2_bad) begin
        sym.pulse_count  <= CNT_NONE;
        sym.pulse_first  <= '0;
        sym.pulse_second <= '0;
        sym.pulse_third  <= '0;
        sym.pulse_fourth <= '0;
      end else begin
        unique case (s2_kind)
          SYM_ONE: begin
            sym.pulse_count  <= CNT_QUAD;
            sym.pulse_first  <= b18;
            sym.pulse_second <= s2_prod;
            sym.pulse_third  <= b18;
            sym.pulse_fourth <= b18;
          end
          SYM_ZERO: begin
            sym.pulse_count  <= CNT_QUAD;
            sym.pulse_first  <= b18;
            sym.pulse_second <= b18;
            sym.pulse_third  <= b18;
            sym.pulse_fourth <= s2_prod;
          end
          default: begin
            sym.pulse_count  <= CNT_PAIR;
            sym.pulse_first  <= b18;
            sym.pulse_second <= s2_prod;
            sym.pulse_third  <= '0;
            sym.pulse_fourth <= '0;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfook_checker.sv =====
// ----------------------------------------------------------------------------
// rfook_checker
// Port-level checks on the symbol output of the screen code encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module rfook_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [2:0]  out_count,
  input wire logic [17:0] out_third,
  input wire logic        out_last,
  input wire logic        out_bad
);
  import rfook_pkg::*;

  // a stalled symbol holds until its transfer
  property p_hold;
    @(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last);
  endproperty
  a_hold: assert property (p_hold) else $error("symbol dropped or changed under stall");

  property p_bad;
    @(posedge clk) disable iff (rst)
      out_valid && out_bad |-> out_last && out_count == CNT_NONE;
  endproperty
  a_bad: assert property (p_bad) else $error("bad id symbol not final or has pulses");

  property p_bit;
    @(posedge clk) disable iff (rst)
      out_valid && (out_kind == SYM_ONE || out_kind == SYM_ZERO)
        |-> out_count == CNT_QUAD && !out_last && !out_bad;
  endproperty
  a_bit: assert property (p_bit) else $error("bit symbol malformed");

  property p_footer;
    @(posedge clk) disable iff (rst)
      out_valid && out_kind == SYM_FOOTER
        |-> out_last && out_count == CNT_PAIR && out_third == '0;
  endproperty
  a_footer: assert property (p_footer) else $error("footer symbol malformed");

endmodule

bind rf_ook_screen_code_pulse_encoder rfook_checker u_rfook_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (sym.valid),
  .out_ready (sym.ready),
  .out_kind  (sym.symbol_kind),
  .out_count (sym.pulse_count),
  .out_third (sym.pulse_third),
  .out_last  (sym.last_symbol),
  .out_bad   (sym.bad_id)
);

`default_nettype wire

// ===== sim/rf_ook_screen_code_pulse_encoder_test.sv =====
// ----------------------------------------------------------------------------
// rf_ook_screen_code_pulse_encoder_test
// Self-checking bench for the screen code pulse encoder. Commands go in from a
// backlog over the command channel. Every accepted command is run through a
// local encoder model, which queues the pulse symbols it should produce. Each
// symbol transfer is compared field by field with the oldest queued symbol.
// Register settings change between phases, while the block is idle.
// ----------------------------------------------------------------------------
module rf_ook_screen_code_pulse_encoder_test;
  import rfook_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_PCT     = 18;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PRINTS   = 40;
  localparam logic [ID_BITS-1:0] ID_MAX = '1;

  typedef struct packed {
    logic [ID_BITS-1:0]   device_id;
    logic                 all_units;
    logic                 move_up;
    logic [UNIT_BITS-1:0] unit_code;
    logic                 hold_for_idle;
  } screen_cmd_t;

  typedef struct {
    sym_kind_t             kind;
    logic [CNT_BITS-1:0]   count;
    logic [PULSE_BITS-1:0] first;
    logic [PULSE_BITS-1:0] second;
    logic [PULSE_BITS-1:0] third;
    logic [PULSE_BITS-1:0] fourth;
    logic                  last;
    logic                  bad;
  } pulse_sym_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  rfook_cmd_if cmd_ch();
  rfook_sym_if sym_ch();

  rf_ook_screen_code_pulse_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .sym       (sym_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // encoder model: register copies and last code word
  logic [BASE_BITS-1:0] base_us;
  logic [LONG_BITS-1:0] long_mult;
  logic [FOOT_BITS-1:0] footer_mult;
  logic [WORD_BITS-1:0] code_word;

  screen_cmd_t cmd_backlog[$];
  pulse_sym_t  sym_due[$];
  screen_cmd_t cmd_next;
  pulse_sym_t  sym_want;
  logic        cmd_taken;
  logic        no_idle;
  int          mismatches;
  int          sym_seen;
  int          cycle_count;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("symbol %0d: %s is %0h, should be %0h", sym_seen, what, got, want);
    mismatches++;
  endtask

  task automatic encode_screen_command(input screen_cmd_t c);
    logic [PULSE_BITS-1:0] b;
    logic [PULSE_BITS-1:0] lng;
    b   = PULSE_BITS'(base_us);
    lng = PULSE_BITS'(long_mult) * b;
    if (c.device_id == '0) begin
      // invalid id: one flagged symbol, code word untouched
      sym_due.push_back('{SYM_START, CNT_NONE, '0, '0, '0, '0, 1'b1, 1'b1});
      return;
    end
    code_word = {c.device_id, c.all_units, c.move_up, c.unit_code};
    sym_due.push_back('{SYM_START, CNT_PAIR, b, PULSE_BITS'(START_MULT) * b, '0, '0,
                        1'b0, 1'b0});
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (code_word[i])
        sym_due.push_back('{SYM_ONE, CNT_QUAD, b, lng, b, b, 1'b0, 1'b0});
      else
        sym_due.push_back('{SYM_ZERO, CNT_QUAD, b, b, b, lng, 1'b0, 1'b0});
    end
    sym_due.push_back('{SYM_FOOTER, CNT_PAIR, b, PULSE_BITS'(footer_mult) * b, '0, '0,
                        1'b1, 1'b0});
  endtask

  // rising edge: register writes, command transfers, symbol checks
  always @(posedge clk) begin
    cmd_taken = 1'b0;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      base_us     = BASE_RESET;
      long_mult   = LONG_RESET;
      footer_mult = FOOTER_RESET;
      code_word   = '0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_BASE_PULSE:    base_us     = cfg_data[BASE_BITS-1:0];
          REG_LONG_FACTOR:   long_mult   = cfg_data[LONG_BITS-1:0];
          REG_FOOTER_FACTOR: footer_mult = cfg_data[FOOT_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        cmd_taken = 1'b1;
        encode_screen_command({cmd_ch.device_id, cmd_ch.all_units, cmd_ch.move_up,
                               cmd_ch.unit_code, 1'b0});
      end
      if (sym_ch.valid && sym_ch.ready) begin
        if (sym_due.size() == 0) begin
          report_mismatch("unexpected transfer, kind", 32'(sym_ch.symbol_kind), '0);
        end else begin
          sym_want = sym_due.pop_front();
          if (sym_ch.symbol_kind !== sym_want.kind)
            report_mismatch("symbol_kind", 32'(sym_ch.symbol_kind), 32'(sym_want.kind));
          if (sym_ch.pulse_count !== sym_want.count)
            report_mismatch("pulse_count", 32'(sym_ch.pulse_count), 32'(sym_want.count));
          if (sym_ch.pulse_first !== sym_want.first)
            report_mismatch("pulse_first", 32'(sym_ch.pulse_first), 32'(sym_want.first));
          if (sym_ch.pulse_second !== sym_want.second)
            report_mismatch("pulse_second", 32'(sym_ch.pulse_second),
                            32'(sym_want.second));
          if (sym_ch.pulse_third !== sym_want.third)
            report_mismatch("pulse_third", 32'(sym_ch.pulse_third), 32'(sym_want.third));
          if (sym_ch.pulse_fourth !== sym_want.fourth)
            report_mismatch("pulse_fourth", 32'(sym_ch.pulse_fourth),
                            32'(sym_want.fourth));
          if (sym_ch.last_symbol !== sym_want.last)
            report_mismatch("last_symbol", 32'(sym_ch.last_symbol), 32'(sym_want.last));
          if (sym_ch.bad_id !== sym_want.bad)
            report_mismatch("bad_id", 32'(sym_ch.bad_id), 32'(sym_want.bad));
        end
        sym_seen++;
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (cmd_backlog.size() == 0 || (!no_idle && $urandom_range(99) < IDLE_PCT)
          || (cmd_backlog[0].hold_for_idle && sym_due.size() != 0)) begin
        cmd_ch.valid <= 1'b0;
      end else begin
        cmd_next = cmd_backlog.pop_front();
        cmd_ch.valid     <= 1'b1;
        cmd_ch.device_id <= cmd_next.device_id;
        cmd_ch.all_units <= cmd_next.all_units;
        cmd_ch.move_up   <= cmd_next.move_up;
        cmd_ch.unit_code <= cmd_next.unit_code;
      end
    end
  end

  // symbol sink
  always @(negedge clk) begin
    sym_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic queue_cmd(input logic [ID_BITS-1:0] id, input logic all,
                           input logic up, input logic [UNIT_BITS-1:0] unit,
                           input logic hold);
    cmd_backlog.push_back({id, all, up, unit, hold});
  endtask

  task automatic queue_random(input int n);
    int r;
    logic [ID_BITS-1:0] id;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 6)
        id = '0;
      else if (r < 16)
        id = ID_BITS'($urandom_range(255, 1));
      else if (r < 24)
        id = ID_MAX - ID_BITS'($urandom_range(255));
      else
        id = ID_BITS'($urandom());
      queue_cmd(id, 1'($urandom()), 1'($urandom()), UNIT_BITS'($urandom()), 1'b0);
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // block idle: nothing queued, nothing offered, nothing due
  task automatic settle();
    while (cmd_backlog.size() != 0 || cmd_ch.valid || sym_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("rf_ook_screen_code_pulse_encoder_test NOT OK");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.device_id = '0;
    cmd_ch.all_units = 1'b0;
    cmd_ch.move_up   = 1'b0;
    cmd_ch.unit_code = '0;
    sym_ch.ready     = 1'b0;
    no_idle          = 1'b0;
    mismatches       = 0;
    sym_seen         = 0;
    cycle_count      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed commands on reset register values
    queue_cmd(ID_MAX, 1'b1, 1'b1, 4'hF, 1'b0);
    queue_cmd(26'd1, 1'b0, 1'b0, 4'h0, 1'b0);
    queue_cmd('0, 1'b1, 1'b1, 4'hF, 1'b0);
    queue_cmd('0, 1'b0, 1'b0, 4'h0, 1'b0);
    queue_cmd(26'h2AAAAAA, 1'b1, 1'b0, 4'hA, 1'b0);
    queue_cmd(26'h1555555, 1'b0, 1'b1, 4'h5, 1'b0);
    queue_cmd(26'h2000000, 1'b0, 1'b0, 4'h0, 1'b0);
    queue_cmd(ID_MAX, 1'b0, 1'b0, 4'h0, 1'b0);
    queue_cmd(26'd1, 1'b1, 1'b1, 4'hF, 1'b0);
    queue_cmd('0, 1'b0, 1'b1, 4'h8, 1'b0);
    queue_cmd(26'h0ABCDEF, 1'b1, 1'b0, 4'h3, 1'b0);
    // sender waits for the encoder to drain before this one
    queue_cmd(26'h3000001, 1'b0, 1'b1, 4'h8, 1'b1);
    queue_cmd(26'h00000FF, 1'b0, 1'b0, 4'h1, 1'b0);
    queue_cmd(26'h3FFFF00, 1'b1, 1'b1, 4'hE, 1'b0);
    queue_cmd(26'h0000155, 1'b0, 1'b1, 4'h7, 1'b0);
    queue_cmd(26'h1000000, 1'b1, 1'b0, 4'h4, 1'b0);
    settle();

    // largest register values
    write_reg(REG_BASE_PULSE, 12'hFFF);
    write_reg(REG_LONG_FACTOR, 12'h00F);
    write_reg(REG_FOOTER_FACTOR, 12'h03F);
    queue_random(30);
    settle();

    // smallest legal values, no idling on either side
    write_reg(REG_BASE_PULSE, 12'h001);
    write_reg(REG_LONG_FACTOR, 12'h001);
    write_reg(REG_FOOTER_FACTOR, 12'h001);
    no_idle = 1'b1;
    queue_random(30);
    settle();
    no_idle = 1'b0;

    // zero factors through masked upper bits, write to the spare index
    write_reg(REG_BASE_PULSE, CFG_BITS'($urandom_range(4095, 1)));
    write_reg(REG_LONG_FACTOR, 12'hFF0);
    write_reg(REG_FOOTER_FACTOR, 12'hFC0);
    write_reg(REG_UNUSED, CFG_BITS'($urandom()));
    queue_random(20);
    settle();

    // zero base pulse
    write_reg(REG_BASE_PULSE, 12'h000);
    write_reg(REG_LONG_FACTOR, CFG_BITS'($urandom_range(15, 1)));
    write_reg(REG_FOOTER_FACTOR, CFG_BITS'($urandom_range(63, 1)));
    queue_random(8);
    settle();

    // random settings, junk in the unused data bits
    write_reg(REG_BASE_PULSE, CFG_BITS'($urandom_range(4095, 1)));
    write_reg(REG_LONG_FACTOR, {8'($urandom()), 4'($urandom_range(15, 1))});
    write_reg(REG_FOOTER_FACTOR, {6'($urandom()), 6'($urandom_range(63, 1))});
    queue_random(25);
    queue_cmd(ID_BITS'($urandom_range(67108863, 1)), 1'b1, 1'b0, 4'h9, 1'b1);
    queue_random(25);
    settle();

    if (mismatches == 0)
      $display("rf_ook_screen_code_pulse_encoder_test OK");
    else
      $display("rf_ook_screen_code_pulse_encoder_test NOT OK");
    $finish;
  end

endmodule
